FILE: src/abc_pkg.sv
package abc_pkg;

    typedef enum logic [1:0] {
        OP_REGISTER = 2'd0,
        OP_CHECK    = 2'd1,
        OP_FREE     = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ILLEGAL = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef struct packed {
        logic [63:0] base;
        logic [31:0] length;
        logic        freed;
    } entry_t;

    localparam int unsigned ENTRY_W = $bits(entry_t);
    localparam logic [11:0] REDZONE_RESET = 12'd16;

endpackage

FILE: src/abc_ram.sv
module abc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: src/allocation_bounds_checker.sv
// Allocation bounds checker. Tracks up to TABLE_ENTRIES allocations in one
// RAM kept sorted by base address; each item (register, check, free or
// none) gives exactly one status item. Every item but a none first runs a
// binary search over the table, a search and a probe state per probe
// because of the RAM's registered read. A register of a new base then
// shifts the entries above its slot up by one, a read and a write state
// per moved entry, so an insert at the bottom of a full-minus-one table
// moves every entry. One item is in work at a time; the status register
// lets the next item enter while a result waits to be taken. No clearing
// pass: entries beyond the fill count are never read. The redzone
// register may be written any time the block is idle.
module allocation_bounds_checker #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [63:0] s_address,
    input  logic [31:0] s_length,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [11:0] cfg_data
);
    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_SEARCH   = 7'b0000010,
        S_PROBE    = 7'b0000100,
        S_DECIDE   = 7'b0001000,
        S_SHIFT_RD = 7'b0010000,
        S_SHIFT_WR = 7'b0100000,
        S_DONE     = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] lo_reg, lo_next, hi_reg, hi_next, k_reg, k_next;
    logic [CW-1:0] count_reg, count_next;
    logic [1:0]    op_reg;
    logic [63:0]   addr_reg;
    logic [31:0]   len_reg;
    abc_pkg::entry_t prev_reg, prev_next, next_reg, next_next;
    logic [11:0]   rz_reg;
    logic [1:0]    status_reg, status_next;
    logic          m_valid_reg;
    logic [1:0]    m_status_reg;

    // RAM port signals
    localparam int ENTRY_WL = abc_pkg::ENTRY_W;
    logic                we;
    logic [AW-1:0]       waddr, raddr;
    abc_pkg::entry_t     wdata, rdata;
    logic [ENTRY_WL-1:0] rdata_raw;

    abc_ram #(.WIDTH(ENTRY_WL), .DEPTH(TABLE_ENTRIES)) u_table (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_raw)
    );
    assign rdata = rdata_raw;

    logic [CW:0]   mid_sum;
    logic [CW-1:0] mid;
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[CW:1];

    // check arithmetic, all modulo 2^64
    logic [63:0] rz64, prev_end, prev_guard, acc_end, next_guard;
    logic        prev_valid, next_valid, prev_hit;
    assign rz64       = {52'd0, rz_reg};
    assign prev_end   = prev_reg.base + {32'd0, prev_reg.length};
    assign prev_guard = prev_end + rz64;
    assign acc_end    = addr_reg + {32'd0, len_reg};
    assign next_guard = next_reg.base - rz64;
    assign prev_valid = (lo_reg != '0);
    assign next_valid = (lo_reg < count_reg);
    assign prev_hit   = prev_valid && (prev_reg.base == addr_reg);

    logic [CW-1:0] lo_m1, k_m1;
    assign lo_m1 = lo_reg - CW'(1);
    assign k_m1  = k_reg - CW'(1);

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_status  = m_status_reg;

    always_comb begin
        state_next  = state_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        k_next      = k_reg;
        count_next  = count_reg;
        prev_next   = prev_reg;
        next_next   = next_reg;
        status_next = status_reg;
        we          = 1'b0;
        waddr       = lo_reg[AW-1:0];
        wdata       = prev_reg;
        raddr       = mid[AW-1:0];
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    lo_next     = '0;
                    hi_next     = count_reg;
                    status_next = abc_pkg::ST_OK;
                    state_next  = (s_operation == abc_pkg::OP_NONE) ? S_DONE : S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (lo_reg < hi_reg) begin
                    state_next = S_PROBE;
                end else begin
                    state_next = S_DECIDE;
                end
            end
            S_PROBE: begin
                // last probe that moved lo is the owning entry; last that moved hi is next
                if (rdata.base <= addr_reg) begin
                    lo_next   = mid + CW'(1);
                    prev_next = rdata;
                end else begin
                    hi_next   = mid;
                    next_next = rdata;
                end
                state_next = S_SEARCH;
            end
            S_DECIDE: begin
                state_next = S_DONE;
                case (op_reg)
                    abc_pkg::OP_REGISTER: begin
                        if (prev_hit) begin
                            we          = 1'b1;
                            waddr       = lo_m1[AW-1:0];
                            wdata.base   = addr_reg;
                            wdata.length = len_reg;
                            wdata.freed  = 1'b0;
                        end else if (count_reg == FULL_COUNT) begin
                            status_next = abc_pkg::ST_FULL;
                        end else begin
                            k_next     = count_reg;
                            state_next = S_SHIFT_RD;
                        end
                    end
                    abc_pkg::OP_CHECK: begin
                        if (prev_valid && (addr_reg < prev_guard)) begin
                            status_next = (!prev_reg.freed && (acc_end <= prev_end)) ?
                                          abc_pkg::ST_OK : abc_pkg::ST_ILLEGAL;
                        end else if (next_valid && (addr_reg >= next_guard)) begin
                            status_next = abc_pkg::ST_ILLEGAL;
                        end
                    end
                    abc_pkg::OP_FREE: begin
                        if (addr_reg == 64'd0) begin
                            status_next = abc_pkg::ST_OK;
                        end else if (prev_hit && !prev_reg.freed) begin
                            we          = 1'b1;
                            waddr       = lo_m1[AW-1:0];
                            wdata.freed = 1'b1;
                        end else begin
                            status_next = abc_pkg::ST_ILLEGAL;
                        end
                    end
                    default: begin
                        status_next = abc_pkg::ST_OK;
                    end
                endcase
            end
            S_SHIFT_RD: begin
                if (k_reg > lo_reg) begin
                    raddr      = k_m1[AW-1:0];
                    state_next = S_SHIFT_WR;
                end else begin
                    we           = 1'b1;
                    waddr        = lo_reg[AW-1:0];
                    wdata.base   = addr_reg;
                    wdata.length = len_reg;
                    wdata.freed  = 1'b0;
                    count_next   = count_reg + CW'(1);
                    state_next   = S_DONE;
                end
            end
            S_SHIFT_WR: begin
                we         = 1'b1;
                waddr      = k_reg[AW-1:0];
                wdata      = rdata;
                k_next     = k_m1;
                state_next = S_SHIFT_RD;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            rz_reg      <= abc_pkg::REDZONE_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_valid) begin
                rz_reg <= cfg_data;
            end
            if (state_reg == S_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        k_reg      <= k_next;
        prev_reg   <= prev_next;
        next_reg   <= next_next;
        status_reg <= status_next;
        if (state_reg == S_IDLE && s_valid) begin
            op_reg   <= s_operation;
            addr_reg <= s_address;
            len_reg  <= s_length;
        end
        if (state_reg == S_DONE && (!m_valid_reg || m_ready)) begin
            m_status_reg <= status_reg;
        end
    end
endmodule

FILE: src/abc_checker.sv
module abc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_status
);
    // status code 3 is never produced
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == abc_pkg::ST_OK || m_status == abc_pkg::ST_ILLEGAL ||
                     m_status == abc_pkg::ST_FULL))
        else $error("bad status code");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_status)))
        else $error("result item changed while stalled");

    // one item in work at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while busy");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");
endmodule

bind allocation_bounds_checker abc_checker u_abc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_status (m_status)
);

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    // one pending request item
    typedef struct {
        abc_pkg::op_t op;
        logic [63:0]  addr;
        logic [31:0]  len;
    } req_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_operation = abc_pkg::OP_NONE;
    logic [63:0] s_address = '0;
    logic [31:0] s_length = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [11:0] cfg_data = '0;

    allocation_bounds_checker #(.TABLE_ENTRIES(256)) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_address   (s_address),
        .s_length    (s_length),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always #6 aclk = ~aclk;

    // shadow of the allocation table, sorted by base
    logic [63:0] tbl_base [256];
    logic [31:0] tbl_len [256];
    logic        tbl_freed [256];
    int unsigned tbl_count = 0;
    logic [11:0] guard_bytes = abc_pkg::REDZONE_RESET;

    req_t              pending_q[$];      // items still to be sent
    abc_pkg::status_t  status_q[$];       // predicted status, oldest first
    logic [63:0] base_pool[64];     // bases the random part reuses
    int          fail_cnt = 0;
    int          sent_cnt = 0;
    int          bad_cnt = 0;
    int          full_cnt = 0;
    bit          calm = 1'b0;       // no idling while set
    bit          in_taken = 1'b0;

    // first slot whose base is above addr
    function automatic int unsigned slot_above(logic [63:0] addr);
        int unsigned i = 0;
        while (i < tbl_count && tbl_base[i] <= addr)
            i++;
        return i;
    endfunction

    // applies one item to the shadow table and returns its status
    function automatic abc_pkg::status_t apply_item(req_t r);
        int unsigned pos;
        logic [63:0] stop;
        pos = slot_above(r.addr);
        case (r.op)
            abc_pkg::OP_REGISTER: begin
                if (pos > 0 && tbl_base[pos-1] == r.addr) begin
                    tbl_len[pos-1] = r.len;
                    tbl_freed[pos-1] = 1'b0;
                    return abc_pkg::ST_OK;
                end
                if (tbl_count >= 256)
                    return abc_pkg::ST_FULL;
                for (int k = tbl_count; k > pos; k--) begin
                    tbl_base[k] = tbl_base[k-1];
                    tbl_len[k] = tbl_len[k-1];
                    tbl_freed[k] = tbl_freed[k-1];
                end
                tbl_base[pos] = r.addr;
                tbl_len[pos] = r.len;
                tbl_freed[pos] = 1'b0;
                tbl_count++;
                return abc_pkg::ST_OK;
            end
            abc_pkg::OP_CHECK: begin
                if (pos > 0) begin
                    stop = tbl_base[pos-1] + 64'(tbl_len[pos-1]);
                    // owning allocation or its trailing guard
                    if (r.addr < stop + 64'(guard_bytes)) begin
                        if (!tbl_freed[pos-1] && r.addr + 64'(r.len) <= stop)
                            return abc_pkg::ST_OK;
                        return abc_pkg::ST_ILLEGAL;
                    end
                end
                // leading guard of the next allocation
                if (pos < tbl_count && r.addr >= tbl_base[pos] - 64'(guard_bytes))
                    return abc_pkg::ST_ILLEGAL;
                return abc_pkg::ST_OK;
            end
            abc_pkg::OP_FREE: begin
                if (r.addr == 0)
                    return abc_pkg::ST_OK;   // null free
                if (pos > 0 && tbl_base[pos-1] == r.addr && !tbl_freed[pos-1]) begin
                    tbl_freed[pos-1] = 1'b1;
                    return abc_pkg::ST_OK;
                end
                return abc_pkg::ST_ILLEGAL;
            end
            default: return abc_pkg::ST_OK;
        endcase
    endfunction

    function automatic bit idle_now();
        return !calm && ($urandom_range(99) < 10);
    endfunction

    // request driver: loads a new item at the falling edge once the last was taken
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || in_taken)) begin
            in_taken = 1'b0;
            if (pending_q.size() != 0 && !idle_now()) begin
                req_t r;
                r = pending_q.pop_front();
                s_operation <= r.op;
                s_address <= r.addr;
                s_length <= r.len;
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver back-pressure
    always @(negedge aclk) begin
        if (aresetn)
            m_ready <= !idle_now();
    end

    // request side: predict on acceptance
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            req_t r;
            abc_pkg::status_t st;
            r.op = abc_pkg::op_t'(s_operation);
            r.addr = s_address;
            r.len = s_length;
            st = apply_item(r);
            status_q.push_back(st);
            in_taken = 1'b1;
            sent_cnt++;
            if (st == abc_pkg::ST_ILLEGAL) bad_cnt++;
            if (st == abc_pkg::ST_FULL) full_cnt++;
        end
    end

    // result side: compare against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (status_q.size() == 0) begin
                $error("unexpected status item %0d", m_status);
                fail_cnt++;
            end else begin
                abc_pkg::status_t want;
                want = status_q.pop_front();
                if (m_status !== want) begin
                    $error("status: expected %0d, got %0d", want, m_status);
                    fail_cnt++;
                end
            end
        end
    end

    // redzone write; only called with the block idle
    task automatic set_guard(logic [11:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        guard_bytes = val;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic add(abc_pkg::op_t op, logic [63:0] addr, logic [31:0] len);
        req_t r;
        r.op = op;
        r.addr = addr;
        r.len = len;
        pending_q.push_back(r);
    endtask

    // waits until every item is sent and answered
    task automatic drain();
        @(posedge aclk);
        while (pending_q.size() != 0 || s_valid || status_q.size() != 0)
            @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    // random item, mostly aimed at pooled allocations and their guards
    task automatic add_random();
        int unsigned pick;
        logic [63:0] b;
        logic [63:0] full;
        pick = $urandom_range(99);
        b = base_pool[$urandom_range(63)];
        full = {$urandom, $urandom};
        if (pick < 30)
            add(abc_pkg::OP_REGISTER, (pick < 3) ? full : b,
                (pick < 6) ? $urandom : 32'($urandom_range(6000)));
        else if (pick < 75)
            add(abc_pkg::OP_CHECK,
                (pick < 38) ? full : b + 64'($urandom_range(14000)) - 64'd5000,
                (pick < 42) ? $urandom : 32'($urandom_range(300)));
        else if (pick < 95)
            add(abc_pkg::OP_FREE, (pick < 78) ? full : b, $urandom);
        else if (pick < 98)
            add(abc_pkg::OP_FREE, 64'd0, $urandom);
        else
            add(abc_pkg::OP_NONE, full, $urandom);
    endtask

    initial begin
        logic [31:0] hi_part [4];
        hi_part[0] = 32'h0;
        hi_part[1] = 32'hFFFF_FFFF;
        hi_part[2] = $urandom;
        hi_part[3] = $urandom;
        foreach (base_pool[i])
            base_pool[i] = {hi_part[$urandom_range(3)], 32'($urandom_range(1, 511)) * 32'd8192};

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, each operation, guards, null and repeated free
        add(abc_pkg::OP_CHECK, 64'd100, 32'd4);                      // empty table
        add(abc_pkg::OP_REGISTER, 64'd0, 32'd64);                    // base zero
        add(abc_pkg::OP_REGISTER, 64'h1000, 32'hFFFF_FFFF);           // largest length
        add(abc_pkg::OP_REGISTER, 64'hFFFF_FFFF_FFFF_FFF0, 32'd8);    // top of space
        add(abc_pkg::OP_CHECK, 64'd0, 32'd64);                       // exact fit
        add(abc_pkg::OP_CHECK, 64'd60, 32'd8);                       // overrun
        add(abc_pkg::OP_CHECK, 64'd70, 32'd1);                       // trailing guard
        add(abc_pkg::OP_CHECK, 64'h0FF8, 32'd1);                     // leading guard
        add(abc_pkg::OP_CHECK, 64'hFFFF_FFFF_FFFF_FFF4, 32'd4);       // fits at the top
        add(abc_pkg::OP_CHECK, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF); // sum wraps
        add(abc_pkg::OP_CHECK, 64'hFFFF_FFFF_FFFF_FFE8, 32'd1);       // guard below top
        add(abc_pkg::OP_FREE, 64'd0, 32'd0);                         // null free
        add(abc_pkg::OP_FREE, 64'h1000, 32'hFFFF_FFFF);               // free live entry
        add(abc_pkg::OP_FREE, 64'h1000, 32'd0);                      // repeated free
        add(abc_pkg::OP_CHECK, 64'h1004, 32'd4);                     // use after free
        add(abc_pkg::OP_FREE, 64'h1234, 32'd0);                      // unknown free
        add(abc_pkg::OP_REGISTER, 64'h1000, 32'd16);                 // same base again
        add(abc_pkg::OP_CHECK, 64'h1004, 32'd4);
        add(abc_pkg::OP_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF); // unused operation
        add(abc_pkg::OP_FREE, 64'hFFFF_FFFF_FFFF_FFF0, 32'd0);
        drain();

        set_guard(12'd0);
        repeat (120) add_random();
        drain();

        set_guard(12'hFFF);
        repeat (120) add_random();
        drain();

        // long stretch without idling on either side
        set_guard(12'($urandom_range(1, 4094)));
        calm = 1'b1;
        repeat (100) add_random();
        drain();
        calm = 1'b0;

        // fill the table to the top, then overflow it
        set_guard(abc_pkg::REDZONE_RESET);
        for (int i = 0; i < 270; i++)
            add(abc_pkg::OP_REGISTER, 64'hFFFF_FFFF_0000_0000 + 64'(i) * 64'h100, 32'd32);
        add(abc_pkg::OP_REGISTER, 64'd0, 32'd1);            // existing base still updates
        repeat (20) add_random();
        drain();

        $display("%0d items sent, %0d illegal and %0d table-full results predicted",
                 sent_cnt, bad_cnt, full_cnt);
        $display("redzone settings 16, 0, 4095 and random; table filled past capacity");
        if (fail_cnt == 0 && status_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
